### hw/rtl/ball_dispenser_jam_monitor_assert.svh
// Assertion macros for the ball dispenser jam monitor RTL.
`ifndef BALL_DISPENSER_JAM_MONITOR_ASSERT_SVH
`define BALL_DISPENSER_JAM_MONITOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that a condition holds at every clock edge outside reset.
`define BDJM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in this cycle implies another in the same cycle.
`define BDJM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition in this cycle implies another in the next cycle.
`define BDJM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BDJM_ASSERT(lbl, cond, msg)
`define BDJM_ASSERT_IMPL(lbl, ante, cons, msg)
`define BDJM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/bdjm_pkg.sv
// Shared types, codes and reset values for the ball dispenser jam monitor.
package bdjm_pkg;

    // Number of player sequencers by default
    localparam int PLAYERS_DEF = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BALLS_PER_ROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JAM_TIMEOUT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_FILTER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_SETTLE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_REPEAT    = 3'd5;

    // Configuration reset values
    localparam logic [15:0] BALLS_PER_ROUND_RST = 16'd10;
    localparam logic [15:0] POLL_INTERVAL_RST   = 16'd10;
    localparam logic [31:0] JAM_TIMEOUT_RST     = 32'd10000;
    localparam logic [15:0] GAP_FILTER_RST      = 16'd100;
    localparam logic [15:0] END_SETTLE_RST      = 16'd1000;
    localparam logic [31:0] ERROR_REPEAT_RST    = 32'd30000;

    // Sequencer phases
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START        = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_LOW     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_GAP          = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_HIGH    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SETTLE       = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ERR_WAIT     = 3'd6;
    localparam logic [PHASE_W-1:0] PH_ERR_ANNOUNCE = 3'd7;

    // Motor commands
    localparam logic [1:0] MOTOR_NONE  = 2'd0;
    localparam logic [1:0] MOTOR_START = 2'd1;
    localparam logic [1:0] MOTOR_STOP  = 2'd2;

    // One poll beat
    typedef struct packed {
        logic [1:0]  player;
        logic [31:0] now_ms;
        logic        coin_waiting;
        logic        sensor_level;
    } in_t;

    // One result beat
    typedef struct packed {
        logic        coin_taken;
        logic [1:0]  motor_cmd;
        logic        error_announce;
        logic        in_error;
        logic [15:0] balls_left;
    } out_t;

    // Configuration register set
    typedef struct packed {
        logic [15:0] balls_per_round;
        logic [15:0] poll_interval;
        logic [31:0] jam_timeout;
        logic [15:0] gap_filter;
        logic [15:0] end_settle;
        logic [31:0] error_repeat;
    } cfg_t;

    // State of one player's sequencer
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [31:0]        last_poll_time;
        logic [31:0]        last_event_time;
        logic [31:0]        last_announce_time;
        logic [15:0]        remaining_balls;
    } player_state_t;

endpackage

### hw/rtl/bdjm_step.sv
// Next-state and result logic for one poll of one player's sequencer.
module bdjm_step
    import bdjm_pkg::*;
(
    input  in_t           item,
    input  player_state_t cur,
    input  cfg_t          cfg,
    output player_state_t nxt,
    output out_t          res
);

    logic [31:0] poll_diff;
    logic [31:0] event_diff;
    logic [31:0] announce_diff;
    logic        poll_ok;
    logic [15:0] balls_dec;

    // Wrapped elapsed times since the stored marks
    assign poll_diff     = item.now_ms - cur.last_poll_time;
    assign event_diff    = item.now_ms - cur.last_event_time;
    assign announce_diff = item.now_ms - cur.last_announce_time;
    assign poll_ok       = poll_diff >= {16'd0, cfg.poll_interval};
    assign balls_dec     = cur.remaining_balls - 16'd1;

    // Advance the sequencer on an accepted poll
    always_comb
    begin
        nxt = cur;
        res = '0;
        if (poll_ok)
        begin
            nxt.last_poll_time = item.now_ms;
            unique case (cur.phase)
                PH_IDLE:
                begin
                    if (item.coin_waiting)
                    begin
                        res.coin_taken      = 1'b1;
                        nxt.remaining_balls = cfg.balls_per_round;
                        nxt.phase           = PH_START;
                    end
                end
                PH_START:
                begin
                    res.motor_cmd       = MOTOR_START;
                    nxt.last_event_time = item.now_ms;
                    nxt.phase           = PH_WAIT_LOW;
                end
                PH_WAIT_LOW:
                begin
                    if (!item.sensor_level)
                    begin
                        nxt.remaining_balls = balls_dec;
                        nxt.last_event_time = item.now_ms;
                        if (balls_dec == 16'd0)
                        begin
                            res.motor_cmd = MOTOR_STOP;
                            nxt.phase     = PH_SETTLE;
                        end
                        else
                        begin
                            nxt.phase = PH_GAP;
                        end
                    end
                    else if (event_diff > cfg.jam_timeout)
                    begin
                        res.motor_cmd = MOTOR_STOP;
                        nxt.phase     = PH_ERR_WAIT;
                    end
                end
                PH_GAP:
                begin
                    if (event_diff > {16'd0, cfg.gap_filter})
                        nxt.phase = PH_WAIT_HIGH;
                end
                PH_WAIT_HIGH:
                begin
                    if (item.sensor_level)
                        nxt.phase = PH_WAIT_LOW;
                end
                PH_SETTLE:
                begin
                    if (event_diff > {16'd0, cfg.end_settle})
                        nxt.phase = PH_IDLE;
                end
                PH_ERR_WAIT:
                begin
                    if (announce_diff > cfg.error_repeat)
                    begin
                        nxt.last_announce_time = item.now_ms;
                        nxt.phase              = PH_ERR_ANNOUNCE;
                    end
                end
                PH_ERR_ANNOUNCE:
                begin
                    nxt.last_announce_time = item.now_ms;
                    res.error_announce     = 1'b1;
                    nxt.phase              = PH_ERR_WAIT;
                end
            endcase
        end
        res.in_error   = (nxt.phase == PH_ERR_WAIT) || (nxt.phase == PH_ERR_ANNOUNCE);
        res.balls_left = nxt.remaining_balls;
    end

endmodule

### hw/rtl/ball_dispenser_jam_monitor.sv
// Ball dispenser jam monitor: top level with per-player state and beat pipeline.
// Each input beat is one poll of one player's dispenser sequencer and yields exactly one
// result beat. Polls pass through an input register, the player's state is read and updated
// combinationally and written back as the result lands in an output register, so a new
// poll is taken every cycle when the output is not stalled. The per-player state registers
// complete the whole read-modify-write at that write-back, so polls of the same player may
// follow each other back to back. Polls for a player index at or above PLAYERS change
// nothing and return an all-zero result. Configuration writes are always taken and should
// only be issued while idle.
`include "ball_dispenser_jam_monitor_assert.svh"

module ball_dispenser_jam_monitor
    import bdjm_pkg::*;
#(
    parameter int PLAYERS = PLAYERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int PIDX_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

    logic          in_vld_reg;
    in_t           in_item_reg;
    logic          out_vld_reg;
    out_t          out_item_reg;
    cfg_t          cfg_reg;
    player_state_t st_reg [PLAYERS];

    logic          out_free;
    logic          advance;
    logic          in_range;
    logic [PIDX_W-1:0] pidx;
    player_state_t cur_state;
    player_state_t st_next;
    out_t          step_res;
    out_t          res_next;

    // Handshake control
    assign out_free  = !out_vld_reg || !out_stall;
    assign in_stall  = in_vld_reg && !out_free;
    assign advance   = in_vld_reg && out_free;
    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    // Select the polled player's state
    assign in_range  = int'(in_item_reg.player) < PLAYERS;
    assign pidx      = PIDX_W'(in_item_reg.player);
    assign cur_state = in_range ? st_reg[pidx] : '0;

    bdjm_step u_step (
        .item (in_item_reg),
        .cur  (cur_state),
        .cfg  (cfg_reg),
        .nxt  (st_next),
        .res  (step_res)
    );

    assign res_next = in_range ? step_res : '0;

    // Capture input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= in_data;
        end
    end

    // Hold result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= res_next;
        end
    end

    // Write back the polled player's state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAYERS; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (advance && in_range)
        begin
            for (int i = 0; i < PLAYERS; i++)
            begin
                if (pidx == PIDX_W'(i))
                begin
                    st_reg[i] <= st_next;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.balls_per_round <= BALLS_PER_ROUND_RST;
            cfg_reg.poll_interval   <= POLL_INTERVAL_RST;
            cfg_reg.jam_timeout     <= JAM_TIMEOUT_RST;
            cfg_reg.gap_filter      <= GAP_FILTER_RST;
            cfg_reg.end_settle      <= END_SETTLE_RST;
            cfg_reg.error_repeat    <= ERROR_REPEAT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BALLS_PER_ROUND: cfg_reg.balls_per_round <= cfg_data[15:0];
                REG_POLL_INTERVAL:   cfg_reg.poll_interval   <= cfg_data[15:0];
                REG_JAM_TIMEOUT:     cfg_reg.jam_timeout     <= cfg_data;
                REG_GAP_FILTER:      cfg_reg.gap_filter      <= cfg_data[15:0];
                REG_END_SETTLE:      cfg_reg.end_settle      <= cfg_data[15:0];
                REG_ERROR_REPEAT:    cfg_reg.error_repeat    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Assertions
    `BDJM_ASSERT_IMPL(a_stall_needs_item, in_stall, in_vld_reg, "input stalled with empty register")
    `BDJM_ASSERT_IMPL(a_announce_in_error, out_valid && out_data.error_announce, out_data.in_error, "error announced outside error state")
    `BDJM_ASSERT_IMPL(a_coin_no_motor, out_valid && out_data.coin_taken, (out_data.motor_cmd == MOTOR_NONE) && !out_data.in_error, "coin taken with motor command or error")

    for (genvar g = 0; g < PLAYERS; g++)
    begin : g_sticky
        `BDJM_ASSERT_NEXT(a_error_sticky, (st_reg[g].phase == PH_ERR_WAIT) || (st_reg[g].phase == PH_ERR_ANNOUNCE), (st_reg[g].phase == PH_ERR_WAIT) || (st_reg[g].phase == PH_ERR_ANNOUNCE), "player left error state")
    end

endmodule
